FILE: rtl/core/caldc_pkg.sv
package caldc_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WDAY_W  = 3;
  localparam int R100_W  = 7;
  localparam int Q100_W  = 8;
  localparam int SUM_W   = 15;

  localparam int DIV100_MUL_W = 13;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = YEAR_W + DIV100_MUL_W;

  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
  localparam logic [YEAR_W-1:0]       HUNDRED    = 14'd100;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam logic [YEAR_W-1:0]  MIN_YEAR   = 14'd1;
  localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd9999;
  localparam logic [YEAR_W-1:0]  RESET_YEAR = 14'd2000;

  localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;

  localparam logic [DAY_W-1:0]   FIRST_DAY  = 5'd1;
  localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd31;

  localparam logic [WDAY_W-1:0]  MONDAY     = 3'd1;
  localparam logic [WDAY_W-1:0]  SATURDAY   = 3'd6;
  localparam logic [WDAY_W-1:0]  SUNDAY     = 3'd7;

  localparam logic [R100_W-1:0]  LAST_R100  = 7'd99;

  typedef struct packed {
    logic               mode;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } item_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  typedef struct packed {
    logic               mode;
    logic               ok;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  wday;
    logic [R100_W-1:0]  r100;
    logic [1:0]         cent;
  } load_info_t;

  function automatic logic leap_of(input logic [R100_W-1:0] r100, input logic [1:0] cent);
    if (r100 == '0) begin
      return cent == 2'd0;
    end
    return r100[1:0] == 2'd0;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap, input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m) inside
      FEBRUARY: len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] sak_offset(input logic [MONTH_W-1:0] m);
    logic [2:0] off;
    case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

FILE: rtl/core/caldc_item_if.sv
interface caldc_item_if;
  import caldc_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [YEAR_W-1:0]  load_year;
  logic [MONTH_W-1:0] load_month;
  logic [DAY_W-1:0]   load_day;

  modport source (output valid, output mode, output load_year, output load_month,
                  output load_day, input ready);
  modport sink (input valid, input mode, input load_year, input load_month,
                input load_day, output ready);
endinterface

FILE: rtl/core/caldc_result_if.sv
interface caldc_result_if;
  import caldc_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  cur_year;
  logic [MONTH_W-1:0] cur_month;
  logic [DAY_W-1:0]   cur_day;
  logic [WDAY_W-1:0]  weekday;
  logic [DAY_W-1:0]   month_length;
  logic               leap_flag;
  logic               new_week;
  logic               new_month;
  logic               new_year;
  logic               load_error;
  logic               overflow;

  modport source (output valid, output cur_year, output cur_month, output cur_day,
                  output weekday, output month_length, output leap_flag,
                  output new_week, output new_month, output new_year,
                  output load_error, output overflow, input ready);
  modport sink (input valid, input cur_year, input cur_month, input cur_day,
                input weekday, input month_length, input leap_flag,
                input new_week, input new_month, input new_year,
                input load_error, input overflow, output ready);
endinterface

FILE: rtl/core/caldc_load_prep.sv
module caldc_load_prep (
  input  logic                  clk,
  input  caldc_pkg::stage_en_t  en,
  input  caldc_pkg::item_t      item,
  output caldc_pkg::load_info_t info
);
  import caldc_pkg::*;

  logic               s1_mode;
  logic [YEAR_W-1:0]  s1_year;
  logic [MONTH_W-1:0] s1_month;
  logic [DAY_W-1:0]   s1_day;
  logic [YEAR_W-1:0]  s1_yp;
  logic               s1_adj;
  logic [Q100_W-1:0]  s1_q100;

  logic               adj;
  logic [YEAR_W-1:0]  yp;
  logic [PROD_W-1:0]  prod;

  logic [YEAR_W-1:0]  rem_full;
  logic [R100_W-1:0]  r100p;
  logic [R100_W-1:0]  r100;
  logic [1:0]         cent;
  logic [SUM_W-1:0]   sum;
  logic [5:0]         fold1;
  logic [3:0]         fold2;
  logic [3:0]         rmod;
  logic [WDAY_W-1:0]  wday;
  logic               ok;

  assign adj  = (item.month == JANUARY) || (item.month == FEBRUARY);
  assign yp   = item.year - YEAR_W'(adj);
  assign prod = PROD_W'(yp) * PROD_W'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_mode  <= item.mode;
      s1_year  <= item.year;
      s1_month <= item.month;
      s1_day   <= item.day;
      s1_yp    <= yp;
      s1_adj   <= adj;
      s1_q100  <= prod[DIV100_SHIFT +: Q100_W];
    end
  end

  assign rem_full = s1_yp - YEAR_W'(s1_q100) * HUNDRED;
  assign r100p    = rem_full[R100_W-1:0];

  assign sum = SUM_W'(s1_yp) + SUM_W'(s1_yp >> 2) - SUM_W'(s1_q100)
             + SUM_W'(s1_q100 >> 2) + SUM_W'(sak_offset(s1_month)) + SUM_W'(s1_day);

  assign fold1 = 6'(sum[2:0]) + 6'(sum[5:3]) + 6'(sum[8:6]) + 6'(sum[11:9])
               + 6'(sum[14:12]);
  assign fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
  assign rmod  = (fold2 >= 4'd7) ? fold2 - 4'd7 : fold2;
  assign wday  = (rmod == 4'd0) ? SUNDAY : rmod[WDAY_W-1:0];

  always_comb begin
    r100 = r100p;
    cent = s1_q100[1:0];
    if (s1_adj) begin
      if (r100p == LAST_R100) begin
        r100 = '0;
        cent = s1_q100[1:0] + 2'd1;
      end else begin
        r100 = r100p + R100_W'(1);
      end
    end
  end

  assign ok = (s1_year >= MIN_YEAR) && (s1_year <= MAX_YEAR)
           && (s1_month >= JANUARY) && (s1_month <= DECEMBER)
           && (s1_day >= FIRST_DAY)
           && (s1_day <= month_len(leap_of(r100, cent), s1_month));

  always_ff @(posedge clk) begin
    if (en.s2) begin
      info.mode  <= s1_mode;
      info.ok    <= ok;
      info.year  <= s1_year;
      info.month <= s1_month;
      info.day   <= s1_day;
      info.wday  <= wday;
      info.r100  <= r100;
      info.cent  <= cent;
    end
  end
endmodule

FILE: rtl/core/calendar_date_counter.sv
// Pipeline: an accepted transaction passes s0, s1 and s2 to the result.
// Throughput: one transaction per cycle unless result.ready stalls; date
// registers update in the last stage; ticks and loads may go back to back.
// Reset: synchronous, clears all stage valids and sets the date to
// 2000-01-01, Saturday.
module calendar_date_counter (
  input logic           clk,
  input logic           rst,
  caldc_item_if.sink    item,
  caldc_result_if.source result
);
  import caldc_pkg::*;

  logic v0, v1, v2, out_valid;
  logic r0, r1, r2, r3;
  logic commit;

  item_t      s0;
  load_info_t s2;
  stage_en_t  en;

  logic [YEAR_W-1:0]  year, year_next;
  logic [MONTH_W-1:0] month, month_next;
  logic [DAY_W-1:0]   day, day_next;
  logic [WDAY_W-1:0]  wday, wday_next;
  logic [R100_W-1:0]  r100, r100_next;
  logic [1:0]         cent, cent_next;
  logic               lerr, ovf, leap_next;

  assign r3 = !out_valid || result.ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign r0 = !v0 || r1;
  assign item.ready = r0;
  assign result.valid = out_valid;
  assign commit = v2 && r3;

  assign en.s1 = r1;
  assign en.s2 = r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r0) v0 <= item.valid;
      if (r1) v1 <= v0;
      if (r2) v2 <= v1;
      if (r3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r0 && item.valid) begin
      s0.mode  <= item.mode;
      s0.year  <= item.load_year;
      s0.month <= item.load_month;
      s0.day   <= item.load_day;
    end
  end

  caldc_load_prep u_prep (
    .clk  (clk),
    .en   (en),
    .item (s0),
    .info (s2)
  );

  always_comb begin
    year_next  = year;
    month_next = month;
    day_next   = day;
    wday_next  = wday;
    r100_next  = r100;
    cent_next  = cent;
    lerr = 1'b0;
    ovf  = 1'b0;
    if (s2.mode == MODE_LOAD) begin
      if (s2.ok) begin
        year_next  = s2.year;
        month_next = s2.month;
        day_next   = s2.day;
        wday_next  = s2.wday;
        r100_next  = s2.r100;
        cent_next  = s2.cent;
      end else begin
        lerr = 1'b1;
      end
    end else if (year == MAX_YEAR && month == DECEMBER && day == LAST_DAY) begin
      ovf = 1'b1;
    end else begin
      wday_next = (wday >= SUNDAY) ? MONDAY : wday + WDAY_W'(1);
      if (day >= month_len(leap_of(r100, cent), month)) begin
        day_next = FIRST_DAY;
        if (month == DECEMBER) begin
          month_next = JANUARY;
          year_next  = year + YEAR_W'(1);
          if (r100 == LAST_R100) begin
            r100_next = '0;
            cent_next = cent + 2'd1;
          end else begin
            r100_next = r100 + R100_W'(1);
          end
        end else begin
          month_next = month + MONTH_W'(1);
        end
      end else begin
        day_next = day + DAY_W'(1);
      end
    end
  end

  assign leap_next = leap_of(r100_next, cent_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      year  <= RESET_YEAR;
      month <= JANUARY;
      day   <= FIRST_DAY;
      wday  <= SATURDAY;
      r100  <= '0;
      cent  <= 2'd0;
    end else if (commit) begin
      year  <= year_next;
      month <= month_next;
      day   <= day_next;
      wday  <= wday_next;
      r100  <= r100_next;
      cent  <= cent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.cur_year     <= year_next;
      result.cur_month    <= month_next;
      result.cur_day      <= day_next;
      result.weekday      <= wday_next;
      result.month_length <= month_len(leap_next, month_next);
      result.leap_flag    <= leap_next;
      result.new_week     <= (wday_next == MONDAY);
      result.new_month    <= (day_next == FIRST_DAY);
      result.new_year     <= (day_next == FIRST_DAY) && (month_next == JANUARY);
      result.load_error   <= lerr;
      result.overflow     <= ovf;
    end
  end
endmodule
